@@ design/stbs_pkg.sv @@
// stbs_pkg: constants, codes, types and helpers shared by the sorted table search unit
// no dependencies; compiled before every other design file
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // lo and hi bounds run from 0 up to TABLE_DEPTH inclusive
  localparam int SPAN_W      = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 11;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_step;
    logic out_busy;
  } dp_sts_t;

  // entry count clamped to the table depth
  function automatic logic [SPAN_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
    logic [SPAN_W-1:0] r;
    if (32'(c) > 32'(TABLE_DEPTH)) begin
      r = SPAN_W'(TABLE_DEPTH);
    end else begin
      r = SPAN_W'(c);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/stbs_if.sv @@
// stbs_if: valid/ready channel interfaces for request items, result items and configuration
// depends on stbs_pkg for the field widths
`default_nettype none

interface stbs_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [stbs_pkg::INDEX_W-1:0]     entry_index;
  logic signed [stbs_pkg::KEY_W-1:0] key_value;

  modport source (output valid, output req_type, output entry_index, output key_value,
                  input ready);
  modport sink   (input valid, input req_type, input entry_index, input key_value,
                  output ready);
endinterface

interface stbs_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [stbs_pkg::POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface stbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [stbs_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface

`default_nettype wire

@@ design/stbs_dp.sv @@
// stbs_dp: key table memory, count register, search bounds and result register
// depends on stbs_pkg; driven by commands from stbs_ctrl
`default_nettype none

module stbs_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire stbs_pkg::dp_cmd_t                 cmd,
  output      stbs_pkg::dp_sts_t                 sts,
  input  wire logic [stbs_pkg::INDEX_W-1:0]      in_entry_index,
  input  wire logic signed [stbs_pkg::KEY_W-1:0] in_key_value,
  input  wire logic                              cfg_valid,
  input  wire logic [stbs_pkg::COUNT_W-1:0]      cfg_entry_count,
  output      logic                              cfg_ready,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic signed [stbs_pkg::POS_W-1:0] out_position
);
  import stbs_pkg::*;

  logic [KEY_W-1:0]        key_table [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rdata_r;
  logic signed [KEY_W-1:0] key_r;
  logic [COUNT_W-1:0]      entry_count_r;
  logic [SPAN_W-1:0]       lo_r, hi_r, lo_nxt, hi_nxt;
  logic [ADDR_W-1:0]       mid_r, mid_nxt, start_mid, rd_addr;
  logic [SPAN_W-1:0]       count_sat;
  logic                    go_left;
  logic                    rd_en;
  logic                    wr_en;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] position_r;

  assign cfg_ready = 1'b1;
  assign count_sat = sat_count(entry_count_r);
  assign start_mid = ADDR_W'(count_sat >> 1);

  // one halving step on the entry read last cycle
  always_comb begin
    go_left = key_r < rdata_r;
    if (go_left) begin
      lo_nxt = lo_r;
      hi_nxt = SPAN_W'(mid_r);
    end else begin
      lo_nxt = SPAN_W'(mid_r) + SPAN_W'(1);
      hi_nxt = hi_r;
    end
    mid_nxt = ADDR_W'(({1'b0, lo_nxt} + {1'b0, hi_nxt}) >> 1);
  end

  assign rd_en   = cmd.start | cmd.step;
  assign rd_addr = cmd.start ? start_mid : mid_nxt;
  assign wr_en   = cmd.write && (32'(in_entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_table[ADDR_W'(in_entry_index)] <= in_key_value;
    end
    if (rd_en) begin
      rdata_r <= key_table[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r  <= '0;
      hi_r  <= count_sat;
      key_r <= in_key_value;
      mid_r <= start_mid;
    end else if (cmd.step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  // result register, frees the search while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      position_r <= POS_W'(hi_r) - POS_W'(1);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = position_r;

  assign sts.count_zero = (count_sat == '0);
  assign sts.last_step  = (lo_nxt == hi_nxt);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

`default_nettype wire

@@ design/stbs_ctrl.sv @@
// stbs_ctrl: state machine sequencing writes, halving steps and result hand-off
// depends on stbs_pkg; commands stbs_dp
`default_nettype none

module stbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output      logic              in_ready,
  input  wire stbs_pkg::dp_sts_t sts,
  output      stbs_pkg::dp_cmd_t cmd
);
  import stbs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = sts.count_zero ? ST_FINISH : ST_SEARCH;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for room in the result register
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/sorted_table_binary_search_unit.sv @@
// sorted_table_binary_search_unit: top level joining controller, datapath and channels
// depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_dp
// write item: taken while idle. query item: a start, halving steps (floor(log2(count))+1
// at most, 11 for a full 1024-entry table) and a result load that waits while an earlier
// result is untaken; the single table read port sets one step per cycle. A query holds
// the input until its result is loaded; the result appears in the cycle after the load.
// reset clears the controller, the result register and entry_count; table contents stay
// undefined until written, with no clearing pass.
`default_nettype none

module sorted_table_binary_search_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  stbs_req_if.sink  in_ch,
  stbs_res_if.source out_ch,
  stbs_cfg_if.sink  cfg_ch
);
  import stbs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  stbs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_ch.entry_index),
    .in_key_value    (in_ch.key_value),
    .cfg_valid       (cfg_ch.valid),
    .cfg_entry_count (cfg_ch.entry_count),
    .cfg_ready       (cfg_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_position    (out_ch.position)
  );

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && cmd.step) && !(cmd.write && cmd.load_out))
    else $error("conflicting datapath commands");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_ch.valid)
    else $error("loaded result not presented");

  a_query_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_QUERY) |=> !in_ch.ready)
    else $error("input taken while a query is searching");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for sorted_table_binary_search_unit, with table loads,
// count changes and key searches under random stalls on both channels
// depends on stbs_pkg, stbs_if and the design files
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 550;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // keeps a copy of the key table and the count, and the positions still owed
  class position_scoreboard;
    logic signed [KEY_W-1:0] key_copy [TABLE_DEPTH];
    logic [COUNT_W-1:0]      entry_count;
    logic signed [POS_W-1:0] expected_positions [$];
    int                      errors;

    function new();
      entry_count = '0;
      errors      = 0;
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endfunction

    function void set_count(logic [COUNT_W-1:0] c);
      entry_count = c;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // last entry not greater than the key, by the same halving steps as the block
    function logic signed [POS_W-1:0] upper_bound_position(logic signed [KEY_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      while (lo != hi) begin
        mid = (lo + hi) / 2;
        if (key < key_copy[mid]) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      return POS_W'(hi - 1);
    endfunction

    function void note_request(logic kind, logic [INDEX_W-1:0] idx,
                               logic signed [KEY_W-1:0] key);
      if (kind == REQ_WRITE) begin
        if (int'(idx) < TABLE_DEPTH) begin
          key_copy[idx] = key;
        end
      end else begin
        expected_positions.push_back(upper_bound_position(key));
      end
    endfunction

    function void check_position(logic signed [POS_W-1:0] got);
      logic signed [POS_W-1:0] want;
      if (expected_positions.size() == 0) begin
        report($sformatf("result position %0d with no query waiting", got));
        return;
      end
      want = expected_positions.pop_front();
      if (got !== want) begin
        report($sformatf("position got %0d expected %0d", got, want));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   sent_items = 0;
  bit   quiet_phase = 1'b0;

  position_scoreboard sb = new();

  stbs_req_if req_ch ();
  stbs_res_if res_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly short idle spans, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 19) < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic int pick_gap();
    if (quiet_phase || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return idle_span();
  endfunction

  // search key near a live entry, at an extreme or anywhere
  function automatic logic signed [KEY_W-1:0] pick_key(int eff);
    int r;
    int i;
    r = $urandom_range(0, 9);
    if (eff == 0 || r < 2) begin
      return $urandom;
    end
    if (r == 2) begin
      return ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
    end
    i = $urandom_range(0, eff - 1);
    return sb.key_copy[i] + ($urandom_range(0, 2) - 1);
  endfunction

  // result side: check every accepted item, stall at random
  initial begin
    int stall;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        sb.check_position(res_ch.position);
      end
      if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        stall = (!quiet_phase && $urandom_range(0, 3) == 0) ? idle_span() : 0;
        res_ch.ready <= (stall == 0);
        if (stall > 0) begin
          stall--;
        end
      end
    end
  end

  task automatic send_request(logic kind, logic [INDEX_W-1:0] idx,
                              logic signed [KEY_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.entry_index <= idx;
    req_ch.key_value   <= key;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, idx, key);
    sent_items++;
  endtask

  task automatic query(logic signed [KEY_W-1:0] key);
    send_request(REQ_QUERY, INDEX_W'($urandom), key);
  endtask

  // only while idle: every result in, then a pause for a write still in flight
  task automatic set_entry_count(logic [COUNT_W-1:0] c);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_count <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_count(c);
    cfg_ch.valid <= 1'b0;
  endtask

  // ascending keys into entries 0..n-1, either spread out or bunched with repeats
  task automatic load_sorted_table(int n);
    int vals [$];
    int base;
    bit bunched;
    bunched = ($urandom_range(0, 2) == 0);
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      vals.push_back(bunched ? base + int'($urandom_range(0, 2 * n)) : int'($urandom));
    end
    vals.sort();
    if (n > 0 && $urandom_range(0, 7) == 0) begin
      vals[0]     = KEY_MIN;
      vals[n - 1] = KEY_MAX;
    end
    for (int i = 0; i < n; i++) begin
      send_request(REQ_WRITE, INDEX_W'(i), vals[i]);
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] c;
    int eff;
    int base_items;
    int r;

    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_WRITE;
    req_ch.entry_index <= '0;
    req_ch.key_value   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.entry_count <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table answers -1 for any key
    set_entry_count('0);
    send_request(REQ_QUERY, '0, KEY_MIN);
    send_request(REQ_QUERY, '1, KEY_MAX);

    send_request(REQ_WRITE, INDEX_W'(0), KEY_MIN);
    send_request(REQ_WRITE, INDEX_W'(1), -5);
    send_request(REQ_WRITE, INDEX_W'(2), 7);
    send_request(REQ_WRITE, INDEX_W'(3), KEY_MAX);
    send_request(REQ_WRITE, '1, 1);

    set_entry_count(COUNT_W'(4));
    query(KEY_MIN);
    query(-6);
    query(-5);
    query(6);
    send_request(REQ_QUERY, '1, 0);
    query(7);
    query(KEY_MAX);

    set_entry_count(COUNT_W'(1));
    query(KEY_MIN);
    query(KEY_MAX);

    // table no longer sorted, same halving steps apply
    send_request(REQ_WRITE, INDEX_W'(1), 100);
    set_entry_count(COUNT_W'(4));
    query(7);
    query(100);

    // whole table, then counts at and above the depth
    load_sorted_table(TABLE_DEPTH);
    set_entry_count(COUNT_W'(TABLE_DEPTH));
    repeat (8) query(pick_key(TABLE_DEPTH));
    set_entry_count('1);
    repeat (4) query(pick_key(TABLE_DEPTH));
    set_entry_count(COUNT_W'(TABLE_DEPTH + 1));
    repeat (4) query(pick_key(TABLE_DEPTH));

    // every entry has now been written, so any count is safe to search
    base_items = sent_items;
    while (sent_items - base_items < RANDOM_ITEMS) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 4) begin
        c = COUNT_W'($urandom_range(0, 8));
      end else if (r < 8) begin
        c = COUNT_W'($urandom_range(9, 64));
      end else if (r == 8) begin
        c = COUNT_W'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: c = '0;
          1: c = COUNT_W'(1);
          2: c = COUNT_W'(TABLE_DEPTH);
          3: c = COUNT_W'(TABLE_DEPTH + 1);
          default: c = '1;
        endcase
      end
      set_entry_count(c);
      eff = (int'(c) > TABLE_DEPTH) ? TABLE_DEPTH : int'(c);
      if (eff <= 64 && $urandom_range(0, 3) != 0) begin
        load_sorted_table(eff);
      end
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(REQ_WRITE, INDEX_W'($urandom), $urandom);
        end else begin
          query(pick_key(eff));
        end
      end
    end

    quiet_phase = 1'b0;
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
